/* sv/fsvt_pkg.sv */
package fsvt_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [2:0] REG_INIT   = 3'd0;
  localparam logic [2:0] REG_FROM_B = 3'd1;
  localparam logic [2:0] REG_FROM_M = 3'd2;
  localparam logic [2:0] REG_FROM_E = 3'd3;
  localparam logic [2:0] REG_FROM_S = 3'd4;

  typedef enum logic [1:0] {
    TAG_B,
    TAG_M,
    TAG_E,
    TAG_S
  } tag_t;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_STEP,
    KIND_DROP
  } kind_t;

  typedef struct packed {
    logic signed [15:0] emit_b;
    logic signed [15:0] emit_m;
    logic signed [15:0] emit_e;
    logic signed [15:0] emit_s;
    logic               end_of_sentence;
  } item_t;

  typedef struct packed {
    logic [1:0] tag;
    logic [5:0] position;
    logic       final_tag;
    logic       overflow;
  } result_t;

  // one classified character between front and core; emit[0] is tag B
  typedef struct packed {
    logic [3:0][15:0] emit;
    logic             last;
    logic             ovf;
    kind_t            kind;
  } qent_t;

  typedef struct packed {
    logic       we;
    logic [5:0] addr;
    logic [1:0] tag;
  } tag_wr_t;

  typedef struct packed {
    logic       start;
    logic [6:0] len;
    logic       ovf;
  } emit_start_t;

  function automatic logic signed [15:0] sat_score(input logic signed [15:0] v,
                                                   input int unsigned sb);
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    hi = 16'((32'sd1 <<< (sb - 1)) - 32'sd1);
    lo = ~hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  function automatic logic signed [23:0] sat_metric(input logic signed [25:0] v);
    if (v > 26'sd8388607) begin
      return 24'sh7fffff;
    end else if (v < -26'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

/* sv/fsvt_front.sv */
module fsvt_front #(
  parameter int MAX_LEN = 64,
  parameter int SCORE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  fsvt_pkg::item_t     item,
  output logic                q_valid,
  output fsvt_pkg::qent_t     q_head,
  input  logic                q_pop
);

  fsvt_pkg::qent_t q [fsvt_pkg::QDEPTH];
  logic [fsvt_pkg::QAW-1:0] wp;
  logic [fsvt_pkg::QAW-1:0] rp;
  logic [fsvt_pkg::QAW:0]   occ;
  logic [6:0]               count;
  logic                     ovf;

  fsvt_pkg::kind_t kind;
  fsvt_pkg::qent_t ent;
  logic            accept;
  logic            enq;
  logic            deq;

  always_comb begin
    if (count == 7'd0) begin
      kind = fsvt_pkg::KIND_FIRST;
    end else if (count < 7'(MAX_LEN)) begin
      kind = fsvt_pkg::KIND_STEP;
    end else begin
      kind = fsvt_pkg::KIND_DROP;
    end
    ent.emit[0] = fsvt_pkg::sat_score(item.emit_b, SCORE_BITS);
    ent.emit[1] = fsvt_pkg::sat_score(item.emit_m, SCORE_BITS);
    ent.emit[2] = fsvt_pkg::sat_score(item.emit_e, SCORE_BITS);
    ent.emit[3] = fsvt_pkg::sat_score(item.emit_s, SCORE_BITS);
    ent.last    = item.end_of_sentence;
    ent.ovf     = ovf | (kind == fsvt_pkg::KIND_DROP);
    ent.kind    = kind;
  end

  assign full    = (occ == (fsvt_pkg::QAW + 1)'(fsvt_pkg::QDEPTH));
  assign accept  = push && !full;
  // dropped characters vanish here unless they close the sentence
  assign enq     = accept && (kind != fsvt_pkg::KIND_DROP || item.end_of_sentence);
  assign q_valid = (occ != '0);
  assign deq     = q_pop && q_valid;
  assign q_head  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      occ   <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      if (enq) begin
        q[wp] <= ent;
        wp    <= wp + 1'b1;
      end
      if (deq) begin
        rp <= rp + 1'b1;
      end
      occ <= occ + (fsvt_pkg::QAW + 1)'(enq) - (fsvt_pkg::QAW + 1)'(deq);
      if (accept) begin
        if (item.end_of_sentence) begin
          count <= '0;
          ovf   <= 1'b0;
        end else if (kind == fsvt_pkg::KIND_DROP) begin
          ovf <= 1'b1;
        end else begin
          count <= count + 7'd1;
        end
      end
    end
  end

endmodule

/* sv/fsvt_core.sv */
module fsvt_core #(
  parameter int MAX_LEN = 64,
  parameter int SCORE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [2:0]            wr_index,
  input  logic [63:0]           wr_data,
  input  logic                  q_valid,
  input  fsvt_pkg::qent_t       q_head,
  output logic                  q_pop,
  input  logic                  emit_busy,
  output fsvt_pkg::tag_wr_t     tag_wr,
  output fsvt_pkg::emit_start_t emit_start
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [1:0] {
    S_RUN,
    S_SEL,
    S_END,
    S_TRACE
  } state_t;

  state_t state;

  logic signed [15:0] init_sc [4];
  logic signed [15:0] trans [4][4];
  logic signed [23:0] pm [4];
  logic signed [23:0] cand [4][4];
  fsvt_pkg::kind_t    kind_q;
  logic               last_q;
  logic               ovf_q;
  logic [6:0]         len;
  logic [6:0]         trace_t;
  logic [1:0]         cur_q;

  logic [7:0]         bp_mem [MAX_LEN];
  logic [7:0]         bp_q;
  logic               bp_we;
  logic               bp_re;
  logic [AW-1:0]      bp_ra;

  logic signed [23:0] sel_pm [4];
  logic [7:0]         sel_row;
  logic [1:0]         ec;
  logic [1:0]         ec_fix;
  logic [1:0]         trace_cur;
  logic               done;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        init_sc[k] <= '0;
        for (int j = 0; j < 4; j++) begin
          trans[k][j] <= '0;
        end
      end
    end else if (wr_en) begin
      unique case (wr_index) inside
        fsvt_pkg::REG_INIT: begin
          for (int k = 0; k < 4; k++) begin
            init_sc[k] <= fsvt_pkg::sat_score(wr_data[16*k +: 16], SCORE_BITS);
          end
        end
        [fsvt_pkg::REG_FROM_B:fsvt_pkg::REG_FROM_S]: begin
          for (int k = 0; k < 4; k++) begin
            trans[2'(wr_index - fsvt_pkg::REG_FROM_B)][k] <=
                fsvt_pkg::sat_score(wr_data[16*k +: 16], SCORE_BITS);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [23:0] best;
    logic [1:0]         arg;
    logic signed [23:0] eb;
    for (int d = 0; d < 4; d++) begin
      best = cand[d][0];
      arg  = 2'd0;
      for (int s = 1; s < 4; s++) begin
        if (cand[d][s] > best) begin
          best = cand[d][s];
          arg  = 2'(s);
        end
      end
      sel_pm[d]          = best;
      sel_row[2*d +: 2]  = arg;
    end
    eb = pm[0];
    ec = fsvt_pkg::TAG_B;
    for (int d = 1; d < 4; d++) begin
      if (pm[d] > eb) begin
        eb = pm[d];
        ec = 2'(d);
      end
    end
    // a sentence cannot close on B or M
    if (ec == fsvt_pkg::TAG_B) begin
      ec_fix = fsvt_pkg::TAG_S;
    end else if (ec == fsvt_pkg::TAG_M) begin
      ec_fix = fsvt_pkg::TAG_E;
    end else begin
      ec_fix = ec;
    end
    trace_cur = bp_q[{cur_q, 1'b0} +: 2];

    q_pop  = 1'b0;
    bp_we  = 1'b0;
    bp_re  = 1'b0;
    bp_ra  = '0;
    tag_wr = '0;
    done   = 1'b0;
    unique case (state)
      S_RUN: begin
        q_pop = q_valid;
      end
      S_SEL: begin
        bp_we = (kind_q != fsvt_pkg::KIND_DROP);
      end
      S_END: begin
        if (!emit_busy) begin
          tag_wr.we   = 1'b1;
          tag_wr.addr = 6'(len - 7'd1);
          tag_wr.tag  = ec_fix;
          if (len == 7'd1) begin
            done = 1'b1;
          end else begin
            bp_re = 1'b1;
            bp_ra = AW'(len - 7'd1);
          end
        end
      end
      S_TRACE: begin
        tag_wr.we   = 1'b1;
        tag_wr.addr = 6'(trace_t - 7'd1);
        tag_wr.tag  = trace_cur;
        if (trace_t == 7'd1) begin
          done = 1'b1;
        end else begin
          bp_re = 1'b1;
          bp_ra = AW'(trace_t - 7'd1);
        end
      end
      default: ;
    endcase
    emit_start.start = done;
    emit_start.len   = len;
    emit_start.ovf   = ovf_q;
  end

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[len[AW-1:0]] <= sel_row;
    end
    if (bp_re) begin
      bp_q <= bp_mem[bp_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      len   <= '0;
      for (int d = 0; d < 4; d++) begin
        pm[d] <= '0;
      end
    end else begin
      unique case (state)
        S_RUN: begin
          if (q_valid) begin
            // first character: metric term zero, init score in place of transition
            for (int d = 0; d < 4; d++) begin
              for (int s = 0; s < 4; s++) begin
                if (q_head.kind == fsvt_pkg::KIND_FIRST) begin
                  cand[d][s] <= fsvt_pkg::sat_metric(26'(init_sc[d])
                                + 26'($signed(q_head.emit[d])));
                end else begin
                  cand[d][s] <= fsvt_pkg::sat_metric(26'(pm[s]) + 26'(trans[s][d])
                                + 26'($signed(q_head.emit[d])));
                end
              end
            end
            kind_q <= q_head.kind;
            last_q <= q_head.last;
            ovf_q  <= q_head.ovf;
            state  <= S_SEL;
          end
        end
        S_SEL: begin
          if (kind_q != fsvt_pkg::KIND_DROP) begin
            for (int d = 0; d < 4; d++) begin
              pm[d] <= sel_pm[d];
            end
            len <= len + 7'd1;
          end
          state <= last_q ? S_END : S_RUN;
        end
        S_END: begin
          if (!emit_busy) begin
            cur_q   <= ec;
            trace_t <= len - 7'd1;
            if (len == 7'd1) begin
              len   <= '0;
              for (int d = 0; d < 4; d++) begin
                pm[d] <= '0;
              end
              state <= S_RUN;
            end else begin
              state <= S_TRACE;
            end
          end
        end
        S_TRACE: begin
          cur_q   <= trace_cur;
          trace_t <= trace_t - 7'd1;
          if (trace_t == 7'd1) begin
            len   <= '0;
            for (int d = 0; d < 4; d++) begin
              pm[d] <= '0;
            end
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  a_start_free: assert property (@(posedge clk) disable iff (rst)
    emit_start.start |-> !emit_busy)
    else $error("emitter started while busy");

  a_tag_free: assert property (@(posedge clk) disable iff (rst)
    tag_wr.we |-> !emit_busy)
    else $error("tag store written while emitter reads it");

  a_pop_sel: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == S_SEL)
    else $error("popped character not selected next cycle");

  a_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL && kind_q != fsvt_pkg::KIND_DROP) |-> len < 7'(MAX_LEN))
    else $error("backpointer row beyond maximum length");

endmodule

/* sv/fsvt_emit.sv */
module fsvt_emit #(
  parameter int MAX_LEN = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fsvt_pkg::tag_wr_t     tag_wr,
  input  fsvt_pkg::emit_start_t emit_start,
  output logic                  busy,
  output logic                  empty,
  input  logic                  pop,
  output fsvt_pkg::result_t     result
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [1:0]        tag_mem [MAX_LEN];
  logic [1:0]        tag_q;
  logic [5:0]        pos_q;
  logic              fin_q;
  logic              ovf_q;
  logic              active;
  logic              inflight;
  logic [6:0]        rd_t;
  logic [6:0]        len_q;

  fsvt_pkg::result_t fifo [2];
  logic              wp;
  logic              rp;
  logic [1:0]        occ;

  logic              issue;
  logic              popd;

  assign issue  = active && ((occ + {1'b0, inflight}) < 2'd2);
  assign popd   = pop && !empty;
  assign busy   = active | inflight;
  assign empty  = (occ == 2'd0);
  assign result = fifo[rp];

  always_ff @(posedge clk) begin
    if (tag_wr.we) begin
      tag_mem[tag_wr.addr[AW-1:0]] <= tag_wr.tag;
    end
    if (issue) begin
      tag_q <= tag_mem[rd_t[AW-1:0]];
      pos_q <= 6'(rd_t);
      fin_q <= (rd_t + 7'd1 == len_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      inflight <= 1'b0;
      rd_t     <= '0;
      wp       <= 1'b0;
      rp       <= 1'b0;
      occ      <= '0;
    end else begin
      inflight <= issue;
      if (emit_start.start) begin
        active <= 1'b1;
        rd_t   <= '0;
        len_q  <= emit_start.len;
        ovf_q  <= emit_start.ovf;
      end else if (issue) begin
        rd_t <= rd_t + 7'd1;
        if (rd_t + 7'd1 == len_q) begin
          active <= 1'b0;
        end
      end
      if (inflight) begin
        fifo[wp] <= '{tag: tag_q, position: pos_q, final_tag: fin_q, overflow: ovf_q};
        wp       <= ~wp;
      end
      if (popd) begin
        rp <= ~rp;
      end
      occ <= occ + 2'(inflight) - 2'(popd);
    end
  end

endmodule

/* sv/four_state_viterbi_tagger.sv */
// channel  | ports                    | transfer when
// ---------+--------------------------+--------------------
// item     | push, full, item         | push && !full
// result   | empty, pop, result       | pop && !empty
// config   | wr_en, wr_index, wr_data | wr_en
//
// Each character passes through S_RUN, which forms the 16 saturated candidates,
// and then S_SEL, which selects survivors; the path-metric loop sets this split.
// Traceback reads one backpointer row a cycle; results then drain through a
// two-entry result FIFO while the next sentence runs. Reset
// is synchronous and clears control state, path metrics and the config
// registers; no clearing pass. full rises when the 4-entry character queue
// fills (core busy with a character, in traceback, or waiting for the previous sentence to drain).
module four_state_viterbi_tagger #(
  parameter int MAX_LEN = 64,
  parameter int SCORE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  fsvt_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output fsvt_pkg::result_t result,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [63:0]       wr_data
);

  logic                  q_valid;
  fsvt_pkg::qent_t       q_head;
  logic                  q_pop;
  logic                  emit_busy;
  fsvt_pkg::tag_wr_t     tag_wr;
  fsvt_pkg::emit_start_t emit_start;

  fsvt_front #(
    .MAX_LEN    (MAX_LEN),
    .SCORE_BITS (SCORE_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  fsvt_core #(
    .MAX_LEN    (MAX_LEN),
    .SCORE_BITS (SCORE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .emit_busy  (emit_busy),
    .tag_wr     (tag_wr),
    .emit_start (emit_start)
  );

  fsvt_emit #(
    .MAX_LEN (MAX_LEN)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .tag_wr     (tag_wr),
    .emit_start (emit_start),
    .busy       (emit_busy),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
